FILE: design/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

  localparam int SEQ_W = 16;
  localparam int CNT_W = 4;
  localparam int WIN_W = 6;
  localparam int TMO_W = 16;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_ACK    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  localparam logic [1:0] REG_TOTAL   = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_RETRY   = 2'd3;

  localparam logic [SEQ_W-1:0] TOTAL_RST   = 16'd0;
  localparam logic [WIN_W-1:0] WINDOW_RST  = 6'd4;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [CNT_W-1:0] RETRY_RST   = 4'd10;

  typedef struct packed {
    logic [1:0]       op;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] total_packets;
    logic [WIN_W-1:0] window_size;
    logic [TMO_W-1:0] timeout_ticks;
    logic [CNT_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic clear_all;
    logic zero;
    logic incr;
  } cnt_op_t;

endpackage

`default_nettype wire

FILE: design/gbn_cfg_regs.sv
`default_nettype none

module gbn_cfg_regs
  import gbn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_packets <= TOTAL_RST;
      cfg_r.window_size   <= WINDOW_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.retry_limit   <= RETRY_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TOTAL:   cfg_r.total_packets <= pwdata[SEQ_W-1:0];
        REG_WINDOW:  cfg_r.window_size   <= pwdata[WIN_W-1:0];
        REG_TIMEOUT: cfg_r.timeout_ticks <= pwdata[TMO_W-1:0];
        REG_RETRY:   cfg_r.retry_limit   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOTAL:   prdata = 32'(cfg_r.total_packets);
      REG_WINDOW:  prdata = 32'(cfg_r.window_size);
      REG_TIMEOUT: prdata = 32'(cfg_r.timeout_ticks);
      REG_RETRY:   prdata = 32'(cfg_r.retry_limit);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/gbn_cnt_store.sv
`default_nettype none

module gbn_cnt_store
  import gbn_pkg::*;
#(
  parameter int WINDOW_MAX = 32,
  parameter int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cnt_op_t          op,
  input  wire logic [SW-1:0]    addr,
  output logic      [CNT_W-1:0] rd_cnt
);

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  logic [CNT_W-1:0] cnt_r [WINDOW_MAX];

  assign rd_cnt = cnt_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n || op.clear_all) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (op.zero) begin
      cnt_r[addr] <= '0;
    end else if (op.incr && cnt_r[addr] != CNT_SAT) begin
      cnt_r[addr] <= cnt_r[addr] + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/go_back_n_sender_window_unit.sv
// go-back-n sender window unit
// input channel (in_valid/in_ready/in_item): one event per item, op start,
// tick or ack with ack_seq. result channel (out_valid/out_ready/out_item):
// one or more results per event, send commands in ascending seq order, then
// done or fail where it applies, a single no-action result for a quiet event;
// last marks the final result of the event.
// configuration via the apb-style port: total_packets, window_size,
// timeout_ticks, retry_limit at byte addresses 0, 4, 8, 12; pready is tied high.
// an event is taken only while the sequencer is idle. after acceptance the
// event state applies the event, a timeout then steps through each outstanding
// packet bumping retry counts through the shared count store, and the fill
// step produces one result per cycle while the receiver accepts. the next
// event can be taken while the last result still waits in the output register.
// a stalled receiver holds the fill step; no result is dropped.
// reset (synchronous, active low) restores register defaults, clears the
// window state and retry counts, and leaves the transfer not running.
`default_nettype none

module go_back_n_sender_window_unit
  import gbn_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int SW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OW   = $clog2(WINDOW_MAX + 1);
  localparam int SUMW = OW + 1;
  localparam logic [SW-1:0]    SLOT_LAST = SW'(WINDOW_MAX - 1);
  localparam logic [SUMW-1:0]  WM_SUM    = SUMW'(WINDOW_MAX);
  localparam logic [WIN_W-1:0] WM_WIN    = WIN_W'(WINDOW_MAX);
  localparam logic [TMO_W-1:0] TICK_SAT  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_TMO,
    ST_FILL
  } state_t;

  cfg_t             cfg;
  cnt_op_t          cnt_op;
  logic [SW-1:0]    cnt_addr;
  logic [CNT_W-1:0] cnt_rd;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [SEQ_W-1:0] ack_r, ack_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] nts_r, nts_nxt;
  logic [SEQ_W-1:0] hs_r, hs_nxt;
  logic [TMO_W-1:0] elapsed_r, elapsed_nxt;
  logic [SW-1:0]    base_slot_r, base_slot_nxt;
  logic [SW-1:0]    nts_slot_r, nts_slot_nxt;
  logic [SW-1:0]    iter_slot_r, iter_slot_nxt;
  logic [OW-1:0]    rem_r, rem_nxt;
  logic             running_r, running_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [WIN_W-1:0] eff_win;
  logic [SEQ_W:0]   limit;
  logic [SEQ_W:0]   nts_inc;
  logic             can_send;
  logic             more;
  logic             first;
  logic             out_free;
  logic [TMO_W-1:0] tick_inc;
  logic [TMO_W-1:0] tick_lim;
  logic [OW-1:0]    ack_off;
  logic [SUMW-1:0]  ack_sum;
  logic [SW-1:0]    ack_slot;

  gbn_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gbn_cnt_store #(
    .WINDOW_MAX (WINDOW_MAX),
    .SW         (SW)
  ) u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (cnt_op),
    .addr   (cnt_addr),
    .rd_cnt (cnt_rd)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cnt_addr  = (state_r == ST_TMO) ? iter_slot_r : nts_slot_r;

  assign eff_win  = (cfg.window_size == '0) ? WIN_W'(1) :
                    ((cfg.window_size > WM_WIN) ? WM_WIN : cfg.window_size);
  assign limit    = {1'b0, base_r} + (SEQ_W+1)'(eff_win);
  assign nts_inc  = {1'b0, nts_r} + 1'b1;
  assign can_send = (nts_r < cfg.total_packets) && ({1'b0, nts_r} < limit);
  assign more     = (nts_inc < {1'b0, cfg.total_packets}) && (nts_inc < limit);
  assign first    = (nts_r >= hs_r);
  assign out_free = !out_valid_r || out_ready;

  assign tick_inc = (elapsed_r != TICK_SAT) ? elapsed_r + 1'b1 : elapsed_r;
  assign tick_lim = (cfg.timeout_ticks == '0) ? TMO_W'(1) : cfg.timeout_ticks;

  assign ack_off  = OW'(ack_r - base_r + 1'b1);
  assign ack_sum  = SUMW'(base_slot_r) + SUMW'(ack_off);
  assign ack_slot = (ack_sum >= WM_SUM) ? SW'(ack_sum - WM_SUM) : SW'(ack_sum);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ack_nxt       = ack_r;
    base_nxt      = base_r;
    nts_nxt       = nts_r;
    hs_nxt        = hs_r;
    elapsed_nxt   = elapsed_r;
    base_slot_nxt = base_slot_r;
    nts_slot_nxt  = nts_slot_r;
    iter_slot_nxt = iter_slot_r;
    rem_nxt       = rem_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    cnt_op        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_item.op;
          ack_nxt   = in_item.ack_seq;
          state_nxt = ST_EVENT;
        end
      end

      ST_EVENT: begin
        state_nxt = ST_FILL;
        if (op_r == OP_START) begin
          base_nxt         = '0;
          nts_nxt          = '0;
          hs_nxt           = '0;
          elapsed_nxt      = '0;
          base_slot_nxt    = '0;
          nts_slot_nxt     = '0;
          running_nxt      = 1'b1;
          cnt_op.clear_all = 1'b1;
        end else if (op_r == OP_TICK && running_r) begin
          elapsed_nxt = tick_inc;
          if (tick_inc >= tick_lim) begin
            elapsed_nxt   = '0;
            nts_nxt       = base_r;
            nts_slot_nxt  = base_slot_r;
            iter_slot_nxt = base_slot_r;
            rem_nxt       = OW'(nts_r - base_r);
            if (nts_r != base_r) begin
              state_nxt = ST_TMO;
            end
          end
        end else if (op_r == OP_ACK && running_r) begin
          if (ack_r >= base_r && ack_r < nts_r) begin
            base_nxt      = ack_r + 1'b1;
            base_slot_nxt = ack_slot;
            elapsed_nxt   = '0;
          end
        end
      end

      // bump the retry count of every outstanding packet
      ST_TMO: begin
        cnt_op.incr   = 1'b1;
        iter_slot_nxt = (iter_slot_r == SLOT_LAST) ? '0 : iter_slot_r + 1'b1;
        rem_nxt       = rem_r - 1'b1;
        if (rem_r == OW'(1)) begin
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt.seq  = '0;
          out_item_nxt.last = 1'b1;
          if (!running_r || op_r == OP_UNUSED) begin
            out_item_nxt.kind = KIND_NONE;
            state_nxt         = ST_IDLE;
          end else if (can_send) begin
            if (!first && cnt_rd > cfg.retry_limit) begin
              out_item_nxt.kind = KIND_FAIL;
              running_nxt       = 1'b0;
              state_nxt         = ST_IDLE;
            end else begin
              if (first) begin
                cnt_op.zero = 1'b1;
                hs_nxt      = SEQ_W'(nts_inc);
              end
              if (base_r == nts_r) begin
                elapsed_nxt = '0;
              end
              out_item_nxt.kind = KIND_SEND;
              out_item_nxt.seq  = nts_r;
              out_item_nxt.last = !more;
              nts_nxt           = SEQ_W'(nts_inc);
              nts_slot_nxt      = (nts_slot_r == SLOT_LAST) ? '0 : nts_slot_r + 1'b1;
              if (!more) begin
                state_nxt = ST_IDLE;
              end
            end
          end else if (base_r >= cfg.total_packets) begin
            out_item_nxt.kind = KIND_DONE;
            running_nxt       = 1'b0;
            state_nxt         = ST_IDLE;
          end else begin
            out_item_nxt.kind = KIND_NONE;
            state_nxt         = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      nts_r       <= '0;
      hs_r        <= '0;
      elapsed_r   <= '0;
      base_slot_r <= '0;
      nts_slot_r  <= '0;
      iter_slot_r <= '0;
      rem_r       <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      nts_r       <= nts_nxt;
      hs_r        <= hs_nxt;
      elapsed_r   <= elapsed_nxt;
      base_slot_r <= base_slot_nxt;
      nts_slot_r  <= nts_slot_nxt;
      iter_slot_r <= iter_slot_nxt;
      rem_r       <= rem_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    ack_r      <= ack_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire
